// ===== hdl/wqac_pkg.sv =====
// wqac_pkg: shared types, constants and the cordic angle table of the waypoint queue
// used by the cordic, core and checker modules of the waypoint queue arrival check block, depends on nothing
package wqac_pkg;

   localparam int COORD_BITS          = 24;
   localparam int ANGLE_BITS          = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int ENTRIES_BITS        = 7;
   localparam int RADIUS_BITS         = 20;
   localparam int TOL_BITS            = 16;
   localparam int CSR_DATA_BITS       = 24;
   localparam int CSR_INDEX_BITS      = 3;
   localparam int CORDIC_STEPS        = 24;
   localparam int CORDIC_SHIFT        = 16;
   localparam int CORDIC_BITS         = COORD_BITS + CORDIC_SHIFT + 3;
   localparam int STEP_BITS           = $clog2(CORDIC_STEPS);
   localparam int MUL_BITS            = (COORD_BITS + 1 > RADIUS_BITS + 1) ?
                                        COORD_BITS + 1 : RADIUS_BITS + 1;
   localparam int DIST_BITS           = 2 * MUL_BITS + 2;
   localparam int YAW_BITS            = ((ANGLE_BITS > TOL_BITS) ? ANGLE_BITS : TOL_BITS) + 2;

   // arctangent of 2^-i in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef enum logic [1:0] {
      MODE_LOAD_POINT = 2'd0,
      MODE_POSITION   = 2'd1,
      MODE_CLEAR      = 2'd2,
      MODE_SET_DEFAULT = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ARRIVAL_RADIUS    = 3'd0,
      CSR_HEADING_TOLERANCE = 3'd1,
      CSR_PLANAR_ONLY       = 3'd2,
      CSR_GOAL_DEPTH        = 3'd3,
      CSR_GOAL_HEADING      = 3'd4
   } csr_index_type;

   typedef struct packed {
      mode_type                      mode;
      logic signed [COORD_BITS-1:0]  north;
      logic signed [COORD_BITS-1:0]  east;
      logic signed [COORD_BITS-1:0]  down;
      logic signed [ANGLE_BITS-1:0]  heading;
      logic                          first_point;
      logic                          last_point;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  target_north;
      logic signed [COORD_BITS-1:0]  target_east;
      logic signed [COORD_BITS-1:0]  target_down;
      logic signed [ANGLE_BITS-1:0]  target_heading;
      logic                          reached;
      logic                          goal_done;
      logic                          push_dropped;
      logic [ENTRIES_BITS-1:0]       entries;
   } rsp_word_type;

   // one queue entry as held in the memory
   typedef struct packed {
      logic signed [COORD_BITS-1:0]  north;
      logic signed [COORD_BITS-1:0]  east;
      logic signed [COORD_BITS-1:0]  down;
      logic signed [ANGLE_BITS-1:0]  heading;
   } entry_type;

   typedef struct packed {
      logic                          start;
      logic signed [COORD_BITS:0]    dx;
      logic signed [COORD_BITS:0]    dy;
   } cordic_req_type;

   typedef struct packed {
      logic                          done;
      logic [ANGLE_BITS-1:0]         angle;
   } cordic_rsp_type;

endpackage

// ===== hdl/wqac_ram.sv =====
// wqac_ram: generic single write port, single read port ram with registered read
// no dependencies
module wqac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end
endmodule

// ===== hdl/wqac_cordic.sv =====
// wqac_cordic: iterative vectoring cordic giving the heading between two points
// depends on wqac_pkg for widths and the angle table
module wqac_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  wqac_pkg::cordic_req_type cordic_req,
   output wqac_pkg::cordic_rsp_type cordic_rsp
);
   import wqac_pkg::*;

   logic signed [CORDIC_BITS-1:0] x_ff, y_ff, sx, sy, xs, ys;
   logic [31:0]                   acc_ff, acc_in, rounded;
   logic [STEP_BITS-1:0]          step_ff;
   logic                          busy_ff, zero_ff, done_ff;
   logic [ANGLE_BITS-1:0]         angle_ff;

   assign sx = CORDIC_BITS'(cordic_req.dx) <<< CORDIC_SHIFT;
   assign sy = CORDIC_BITS'(cordic_req.dy) <<< CORDIC_SHIFT;
   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;
   assign acc_in  = (y_ff >= 0) ? acc_ff + ATAN_TURN[step_ff] : acc_ff - ATAN_TURN[step_ff];
   // round half up to the angle width
   assign rounded = acc_in + (32'd1 << (31 - ANGLE_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cordic_req.start) begin
            // negative north difference: pre-rotate by half a turn
            x_ff    <= (cordic_req.dx < 0) ? -sx : sx;
            y_ff    <= (cordic_req.dx < 0) ? -sy : sy;
            acc_ff  <= (cordic_req.dx < 0) ? 32'h8000_0000 : 32'h0;
            zero_ff <= (cordic_req.dx == 0) && (cordic_req.dy == 0);
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (y_ff >= 0) begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
            end else begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
            end
            acc_ff <= acc_in;
            if (step_ff == STEP_BITS'(CORDIC_STEPS - 1)) begin
               busy_ff  <= 1'b0;
               done_ff  <= 1'b1;
               angle_ff <= zero_ff ? '0 : rounded[31 -: ANGLE_BITS];
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
      end
   end

   assign cordic_rsp.done  = done_ff;
   assign cordic_rsp.angle = angle_ff;
endmodule

// ===== hdl/waypoint_queue_arrival_check_core.sv =====
// waypoint_queue_arrival_check_core: waypoint fifo with path loading and arrival check
// depends on wqac_pkg, wqac_ram and wqac_cordic
//
// One word in, one word out. The queue lives in a single ram (one write and one registered
// read port); the logic reads the head, works on it and writes pushes back, one access at a
// time, so no two accesses to one entry overlap. A word is taken only while the sequencer is
// idle. Work per word: a path point that is not the first waits on the 24 steps of the
// shared cordic unit; a position update on the one shared squaring multiplier, used four
// times; clear and set-default words use neither unit and go straight to the result read.
// The result sits in an output register, so the next word can be taken while it waits.
// No clearing pass after reset: the fill count alone says which entries hold waypoints.
module waypoint_queue_arrival_check_core #(
   parameter int QUEUE_DEPTH = wqac_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  wqac_pkg::req_word_type                 req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output wqac_pkg::rsp_word_type                 rsp_word,
   input  logic                                   csr_write_en,
   input  logic [wqac_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [wqac_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import wqac_pkg::*;

   localparam int HW = $clog2(QUEUE_DEPTH);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = $bits(entry_type);

   typedef enum logic [3:0] {
      S_IDLE, S_CORDIC, S_PUSH_PATH, S_PUSH_GOAL, S_HEAD_RD,
      S_SQUARE, S_ACCUM, S_DECIDE, S_RES_RD, S_OUT
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [RADIUS_BITS-1:0]        radius_ff;
   logic [TOL_BITS-1:0]           tolerance_ff;
   logic                          planar_ff;
   logic signed [COORD_BITS-1:0]  goal_depth_ff;
   logic signed [ANGLE_BITS-1:0]  goal_heading_ff;

   // queue control and the small state
   logic [HW-1:0]                 head_ff;
   logic [FW-1:0]                 fill_ff;
   logic signed [COORD_BITS-1:0]  prev_north_ff, prev_east_ff;
   entry_type                     fallback_ff;

   // per word working registers
   req_word_type                  req_ff;
   logic                          reached_ff, done_ff, dropped_ff;
   logic [1:0]                    sq_step_ff;
   logic [2*MUL_BITS-1:0]         prod_ff;
   logic [DIST_BITS-1:0]          dist_ff;
   logic [2*MUL_BITS-1:0]         radius_sq_ff;
   logic [ANGLE_BITS-1:0]         path_heading_ff;

   logic                          rsp_valid_ff;
   rsp_word_type                  rsp_word_ff;

   // memory port signals
   logic                          ram_wr_en, ram_rd_en;
   logic [HW-1:0]                 tail_slot;
   logic [HW:0]                   slot_sum;
   entry_type                     ram_wr_data, head_entry;
   logic [EW-1:0]                 ram_rd_data;

   cordic_req_type                cordic_req;
   cordic_rsp_type                cordic_rsp;

   logic                          accept, queue_full, arrive, out_load;
   logic signed [COORD_BITS:0]    diff_n, diff_e, diff_d;
   logic signed [MUL_BITS-1:0]    sq_operand;
   logic signed [2*MUL_BITS-1:0]  sq_product;
   logic signed [ANGLE_BITS-1:0]  yaw;
   logic [HW-1:0]                 head_in;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign queue_full = (fill_ff == FW'(QUEUE_DEPTH));
   assign head_entry = entry_type'(ram_rd_data);
   // result register takes a new word once it is empty or being drained
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   // tail = (head + fill) mod depth, the sum stays below twice the depth
   assign slot_sum  = {1'b0, head_ff} + (HW+1)'(fill_ff);
   assign tail_slot = (slot_sum >= (HW+1)'(QUEUE_DEPTH)) ?
                      HW'(slot_sum - (HW+1)'(QUEUE_DEPTH)) : HW'(slot_sum);
   assign head_in   = (head_ff == HW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // pushes: path waypoint takes the cordic heading, goal waypoint the goal heading
   assign ram_wr_en = ((state_ff == S_PUSH_PATH) || (state_ff == S_PUSH_GOAL)) && !queue_full;
   always_comb begin
      ram_wr_data.north   = req_ff.north;
      ram_wr_data.east    = req_ff.east;
      ram_wr_data.down    = goal_depth_ff;
      ram_wr_data.heading = (state_ff == S_PUSH_PATH) ? path_heading_ff : goal_heading_ff;
   end
   assign ram_rd_en = (state_ff == S_HEAD_RD) || ((state_ff == S_RES_RD) && (fill_ff != '0));

   wqac_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (tail_slot),
      .wr_data    (ram_wr_data),
      .rd_en      (ram_rd_en),
      .rd_addr    (head_ff),
      .rd_data_ff (ram_rd_data)
   );

   // heading from previous point to this one, operands taken at accept
   always_comb begin
      cordic_req.start = accept && (req_word.mode == MODE_LOAD_POINT) && !req_word.first_point;
      cordic_req.dx    = (COORD_BITS+1)'(req_word.north) - (COORD_BITS+1)'(prev_north_ff);
      cordic_req.dy    = (COORD_BITS+1)'(req_word.east) - (COORD_BITS+1)'(prev_east_ff);
   end

   wqac_cordic u_cordic (
      .clock      (clock),
      .reset      (reset),
      .cordic_req (cordic_req),
      .cordic_rsp (cordic_rsp)
   );

   // arrival check: head minus position, squared one term per pass
   assign diff_n = (COORD_BITS+1)'(head_entry.north) - (COORD_BITS+1)'(req_ff.north);
   assign diff_e = (COORD_BITS+1)'(head_entry.east) - (COORD_BITS+1)'(req_ff.east);
   assign diff_d = (COORD_BITS+1)'(head_entry.down) - (COORD_BITS+1)'(req_ff.down);
   always_comb begin
      unique case (sq_step_ff)
         2'd0:    sq_operand = MUL_BITS'(diff_n);
         2'd1:    sq_operand = MUL_BITS'(diff_e);
         2'd2:    sq_operand = planar_ff ? '0 : MUL_BITS'(diff_d);
         default: sq_operand = $signed(MUL_BITS'(radius_ff));
      endcase
   end
   // full width square, never negative
   assign sq_product = sq_operand * sq_operand;
   // wrapped signed yaw difference against the unsigned tolerance
   assign yaw    = head_entry.heading - req_ff.heading;
   assign arrive = (dist_ff < DIST_BITS'(radius_sq_ff)) &&
                   ($signed(YAW_BITS'(yaw)) < $signed(YAW_BITS'(tolerance_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         radius_ff       <= RADIUS_BITS'(50);
         tolerance_ff    <= TOL_BITS'(2048);
         planar_ff       <= 1'b0;
         goal_depth_ff   <= '0;
         goal_heading_ff <= '0;
         head_ff         <= '0;
         fill_ff         <= '0;
         prev_north_ff   <= '0;
         prev_east_ff    <= '0;
         fallback_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_ARRIVAL_RADIUS:    radius_ff       <= csr_data[RADIUS_BITS-1:0];
               CSR_HEADING_TOLERANCE: tolerance_ff    <= csr_data[TOL_BITS-1:0];
               CSR_PLANAR_ONLY:       planar_ff       <= csr_data[0];
               CSR_GOAL_DEPTH:        goal_depth_ff   <= csr_data[COORD_BITS-1:0];
               CSR_GOAL_HEADING:      goal_heading_ff <= csr_data[ANGLE_BITS-1:0];
               default: ;
            endcase
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  req_ff     <= req_word;
                  reached_ff <= 1'b0;
                  done_ff    <= 1'b0;
                  dropped_ff <= 1'b0;
                  unique case (req_word.mode)
                     MODE_LOAD_POINT: begin
                        prev_north_ff <= req_word.north;
                        prev_east_ff  <= req_word.east;
                        if (!req_word.first_point) begin
                           state_ff <= S_CORDIC;
                        end else if (req_word.last_point) begin
                           state_ff <= S_PUSH_GOAL;
                        end else begin
                           state_ff <= S_RES_RD;
                        end
                     end
                     MODE_POSITION: begin
                        if (fill_ff == '0) begin
                           done_ff  <= 1'b1;
                           state_ff <= S_RES_RD;
                        end else begin
                           state_ff <= S_HEAD_RD;
                        end
                     end
                     MODE_CLEAR: begin
                        head_ff  <= '0;
                        fill_ff  <= '0;
                        state_ff <= S_RES_RD;
                     end
                     MODE_SET_DEFAULT: begin
                        fallback_ff.north   <= req_word.north;
                        fallback_ff.east    <= req_word.east;
                        fallback_ff.down    <= req_word.down;
                        fallback_ff.heading <= req_word.heading;
                        state_ff            <= S_RES_RD;
                     end
                  endcase
               end
            end
            S_CORDIC: begin
               if (cordic_rsp.done) begin
                  path_heading_ff <= cordic_rsp.angle;
                  state_ff        <= S_PUSH_PATH;
               end
            end
            S_PUSH_PATH, S_PUSH_GOAL: begin
               if (queue_full) begin
                  dropped_ff <= 1'b1;
               end else begin
                  fill_ff <= fill_ff + 1'b1;
               end
               state_ff <= (state_ff == S_PUSH_PATH && req_ff.last_point) ?
                           S_PUSH_GOAL : S_RES_RD;
            end
            S_HEAD_RD: begin
               dist_ff    <= '0;
               sq_step_ff <= 2'd0;
               state_ff   <= S_SQUARE;
            end
            S_SQUARE: begin
               prod_ff  <= unsigned'(sq_product);
               state_ff <= S_ACCUM;
            end
            S_ACCUM: begin
               if (sq_step_ff == 2'd3) begin
                  radius_sq_ff <= prod_ff;
                  state_ff     <= S_DECIDE;
               end else begin
                  dist_ff  <= dist_ff + DIST_BITS'(prod_ff);
                  state_ff <= S_SQUARE;
               end
               sq_step_ff <= sq_step_ff + 1'b1;
            end
            S_DECIDE: begin
               if (arrive) begin
                  fallback_ff <= head_entry;
                  head_ff     <= head_in;
                  fill_ff     <= fill_ff - 1'b1;
                  reached_ff  <= 1'b1;
               end
               state_ff <= S_RES_RD;
            end
            S_RES_RD: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // hold until the output register is free
               if (out_load) begin
                  if (fill_ff != '0) begin
                     rsp_word_ff.target_north   <= head_entry.north;
                     rsp_word_ff.target_east    <= head_entry.east;
                     rsp_word_ff.target_down    <= head_entry.down;
                     rsp_word_ff.target_heading <= head_entry.heading;
                  end else begin
                     rsp_word_ff.target_north   <= fallback_ff.north;
                     rsp_word_ff.target_east    <= fallback_ff.east;
                     rsp_word_ff.target_down    <= fallback_ff.down;
                     rsp_word_ff.target_heading <= fallback_ff.heading;
                  end
                  rsp_word_ff.reached      <= reached_ff;
                  rsp_word_ff.goal_done    <= done_ff;
                  rsp_word_ff.push_dropped <= dropped_ff;
                  rsp_word_ff.entries      <= ENTRIES_BITS'(fill_ff);
                  state_ff                 <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
endmodule

// ===== hdl/wqac_checker.sv =====
// wqac_checker: port level assertions for the waypoint queue, bound to the top level
// depends on wqac_pkg and waypoint_queue_arrival_check_core
module wqac_checker #(
   parameter int QUEUE_DEPTH = wqac_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input wqac_pkg::rsp_word_type              rsp_word
);
   import wqac_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // one word at a time: the input is stalled right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while a word is in work");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.reached && rsp_word.goal_done))
      else $error("reached and goal_done both set");

   a_entries_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_word.entries) <= QUEUE_DEPTH))
      else $error("entries beyond queue depth");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.goal_done |-> (rsp_word.entries == '0))
      else $error("goal_done with waypoints held");
endmodule

bind waypoint_queue_arrival_check_core wqac_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_wqac_checker (.*);
